// ----- src/beam_element_particle_tracker_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the particle tracker
// Clocked assertion helpers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef BEAM_ELEMENT_PARTICLE_TRACKER_UNIT_ASSERT_SVH
`define BEAM_ELEMENT_PARTICLE_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BEPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define BEPT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define BEPT_ASSERT(lbl, prop, msg)
`define BEPT_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ----- src/bept_pkg.sv -----
// ----------------------------------------------------------------------------
// Particle tracker package
// Shared types, codes and fixed-point helpers of the tracker pipeline.
// ----------------------------------------------------------------------------
package bept_pkg;

	localparam int W = 32;

	// Element kinds.
	localparam logic [1:0] OP_DRIFT = 2'd0;
	localparam logic [1:0] OP_QUAD  = 2'd1;
	localparam logic [1:0] OP_SEXT  = 2'd2;
	localparam logic [1:0] OP_BAD   = 2'd3;

	// Register indexes and the order code that enables second-order terms.
	localparam logic REG_ORDER = 1'b0;
	localparam logic REG_P0    = 1'b1;
	localparam logic [1:0] ORDER_SECOND = 2'd2;
	localparam logic [1:0] ORDER_RESET  = 2'd1;
	localparam logic [31:0] P0_RESET    = 32'd65536;

	// Momentum correction divider: quotient bits and bits per stage.
	localparam int QBITS      = 34;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = QBITS / DIV_STEPS;
	localparam logic [QBITS-1:0] Q_CLAMP = 34'h2_0000_0000;

	// Aperture check stages.
	localparam int ELL_STAGES = 4;

	typedef struct packed {
		logic [1:0]          op;
		logic signed [W-1:0] len;
		logic signed [W-1:0] k0;
		logic signed [W-1:0] x;
		logic signed [W-1:0] xa;
		logic signed [W-1:0] y;
		logic signed [W-1:0] ya;
		logic signed [W-1:0] l;
		logic signed [W-1:0] d;
		logic signed [W-1:0] aph;
		logic signed [W-1:0] apv;
		logic signed [W-1:0] nh;
		logic                bad;
		logic                kadd;
	} item_t;

	typedef struct packed {
		logic signed [W-1:0] x;
		logic signed [W-1:0] xa;
		logic signed [W-1:0] y;
		logic signed [W-1:0] ya;
		logic signed [W-1:0] l;
	} coord_t;

	function automatic logic signed [W-1:0] sat32(input logic signed [40:0] v);
		if (v > 41'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -41'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[W-1:0];
	endfunction

	// Q8.24 product, floored, saturated.
	function automatic logic signed [W-1:0] qmul(input logic signed [W:0] a,
		input logic signed [W-1:0] b);
		logic signed [2*W:0] p;
		p = a * b;
		return sat32($signed(p[2*W:24]));
	endfunction

	function automatic logic [W-1:0] mag32(input logic signed [W-1:0] v);
		return (v < 0) ? W'(-v) : W'(v);
	endfunction

endpackage

// ----- src/bept_div.sv -----
// ----------------------------------------------------------------------------
// Momentum correction divider
// Restoring division, two quotient bits per pipeline stage.
// ----------------------------------------------------------------------------
module bept_div import bept_pkg::*; (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  logic [W-1:0]          divisor,
	input  logic [W-1:0]          rem_in,
	input  logic [QBITS-1:0]      nq_in,
	input  logic                  ovf_in,
	output logic [QBITS-1:0]      quot,
	output logic                  ovf
);

	logic [W-1:0]     rem_s [DIV_STAGES];
	logic [QBITS-1:0] nq_s  [DIV_STAGES];
	logic             ovf_s [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_st
		logic [W-1:0]     r_prev;
		logic [QBITS-1:0] n_prev;
		logic             o_prev;
		logic [W-1:0]     r_next;
		logic [QBITS-1:0] n_next;

		if (j == 0) begin : g_first
			assign r_prev = rem_in;
			assign n_prev = nq_in;
			assign o_prev = ovf_in;
		end else begin : g_next
			assign r_prev = rem_s[j-1];
			assign n_prev = nq_s[j-1];
			assign o_prev = ovf_s[j-1];
		end

		// The numerator bits leave the top of nq while quotient bits enter below.
		always_comb begin
			logic [W:0] t;
			r_next = r_prev;
			n_next = n_prev;
			for (int k = 0; k < DIV_STEPS; k++) begin
				t = {r_next, n_next[QBITS-1]};
				n_next = {n_next[QBITS-2:0], 1'b0};
				if (t >= {1'b0, divisor}) begin
					r_next = W'(t - {1'b0, divisor});
					n_next[0] = 1'b1;
				end else begin
					r_next = t[W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j] <= r_next;
				nq_s[j]  <= n_next;
				ovf_s[j] <= o_prev;
			end
		end
	end

	assign quot = nq_s[DIV_STAGES-1];
	assign ovf  = ovf_s[DIV_STAGES-1];

endmodule

// ----- src/bept_ellipse.sv -----
// ----------------------------------------------------------------------------
// Elliptical aperture check
// Exact test x^2*b^2 + y^2*a^2 <= a^2*b^2 over four stages.
// ----------------------------------------------------------------------------
module bept_ellipse import bept_pkg::*; (
	input  logic                  clk,
	input  logic [ELL_STAGES-1:0] en,
	input  logic signed [W-1:0]   px,
	input  logic signed [W-1:0]   py,
	input  logic signed [W-1:0]   aph,
	input  logic signed [W-1:0]   apv,
	output logic                  in_ellipse
);

	// Squares: x^2, y^2, a^2, b^2.
	logic [2*W-1:0]  sq_s1   [4];
	logic [2*W-1:0]  pp_s2   [3][4];
	logic [4*W-1:0]  full_s3 [3];
	logic            in_ellipse_s4;

	logic [W-1:0] m [4];
	assign m[0] = mag32(px);
	assign m[1] = mag32(py);
	assign m[2] = mag32(aph);
	assign m[3] = mag32(apv);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 4; i++)
				sq_s1[i] <= m[i] * m[i];
		end
	end

	// Products x2*b2, y2*a2, a2*b2, each as four 32x32 partial products.
	logic [2*W-1:0] opa [3];
	logic [2*W-1:0] opb [3];
	assign opa[0] = sq_s1[0];
	assign opb[0] = sq_s1[3];
	assign opa[1] = sq_s1[1];
	assign opb[1] = sq_s1[2];
	assign opa[2] = sq_s1[2];
	assign opb[2] = sq_s1[3];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int n = 0; n < 3; n++) begin
				pp_s2[n][0] <= opa[n][W-1:0]   * opb[n][W-1:0];
				pp_s2[n][1] <= opa[n][W-1:0]   * opb[n][2*W-1:W];
				pp_s2[n][2] <= opa[n][2*W-1:W] * opb[n][W-1:0];
				pp_s2[n][3] <= opa[n][2*W-1:W] * opb[n][2*W-1:W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int n = 0; n < 3; n++)
				full_s3[n] <= (4*W)'(pp_s2[n][0])
					+ ((4*W)'(pp_s2[n][1]) << W)
					+ ((4*W)'(pp_s2[n][2]) << W)
					+ ((4*W)'(pp_s2[n][3]) << (2*W));
		end
	end

	always_ff @(posedge clk) begin
		if (en[3])
			in_ellipse_s4 <= ((4*W+1)'(full_s3[0]) + (4*W+1)'(full_s3[1]))
				<= (4*W+1)'(full_s3[2]);
	end

	assign in_ellipse = in_ellipse_s4;

endmodule

// ----- src/beam_element_particle_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// Beam element particle tracker
// Tracks one particle through a drift, thin quadrupole or thin sextupole per
// item, with optional second-order terms and an elliptical aperture check.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_*       in         element kind (tuser), length, strength, momentum,
//                       six coordinates, two aperture half-axes (tdata)
//  m_*       out        six new coordinates (tdata), survived and rejected
//                       flags (tuser)
//  cfg_*     in         register writes: transport order, reference momentum
//
// One item enters per clock cycle unless every stage is full and the output
// stalls. Most of the pipeline is the momentum correction divider, which
// retires two quotient bits per stage over seventeen stages; the aperture
// check adds four. Reset clears the stage valid bits and loads the register
// reset values; the data registers are not reset.
// A stall at the output halts only the full stages behind it, so empty stages
// keep filling and an item is taken while a result waits.
//
`include "beam_element_particle_tracker_unit_assert.svh"

module beam_element_particle_tracker_unit import bept_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	// Input items.
	input  logic           s_tvalid,
	output logic           s_tready,
	// elem_length, strength, momentum, x_pos, x_angle, y_pos, y_angle,
	// path_delta, momentum_dev, aperture_h, aperture_v (32 bits each)
	input  logic [351:0]   s_tdata,
	// opcode
	input  logic [1:0]     s_tuser,
	// Result items.
	output logic           m_tvalid,
	input  logic           m_tready,
	// x_out, xa_out, y_out, ya_out, path_out, dev_out (32 bits each)
	output logic [191:0]   m_tdata,
	// survived, bad_element
	output logic [1:0]     m_tuser,
	// Configuration writes.
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_data
);

	// Stage map: 1 capture, 2 correction product, 3 divider setup,
	// 4..20 divider, 21 strength, 22 integrated strength, 23 and 24 products,
	// 25 sums, 26..29 aperture checks.
	localparam int ST_DIV0 = 3;
	localparam int ST_K    = ST_DIV0 + DIV_STAGES + 1;
	localparam int ST_KL   = ST_K + 1;
	localparam int ST_M1   = ST_KL + 1;
	localparam int ST_M2   = ST_M1 + 1;
	localparam int ST_SUM  = ST_M2 + 1;
	localparam int NST     = ST_SUM + ELL_STAGES;

	// Config registers; user changes them only with pipeline empty, unchecked.
	logic [1:0]   order_q;
	logic [W-1:0] p0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
			p0_q    <= P0_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORDER: order_q <= cfg_data[1:0];
				REG_P0:    p0_q    <= cfg_data;
				default:   order_q <= order_q;
			endcase
		end
	end

	logic second;
	assign second = (order_q == ORDER_SECOND);

	// Stage control. A stage loads when the output moves or some stage at or
	// after it is empty, which lets bubbles collapse under a stall.
	logic [NST:1] vld_s;
	logic [NST:1] en;
	logic [NST:1] vld_in;

	for (genvar i = 1; i <= NST; i++) begin : g_en
		assign en[i] = m_tready | ~(&vld_s[NST:i]);
	end

	assign vld_in = {vld_s[NST-1:1], s_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 1; i <= NST; i++)
				if (en[i])
					vld_s[i] <= vld_in[i];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_s[NST];

	// Stage 1: capture, validity checks and the sign work for the correction.
	item_t               item_in;
	logic signed [W:0]   dp;
	logic [W-1:0]        mk_in;
	logic [W-1:0]        mdp_in;

	always_comb begin
		item_in.op   = s_tuser;
		item_in.len  = $signed(s_tdata[0*W +: W]);
		item_in.k0   = $signed(s_tdata[1*W +: W]);
		item_in.x    = $signed(s_tdata[3*W +: W]);
		item_in.xa   = $signed(s_tdata[4*W +: W]);
		item_in.y    = $signed(s_tdata[5*W +: W]);
		item_in.ya   = $signed(s_tdata[6*W +: W]);
		item_in.l    = $signed(s_tdata[7*W +: W]);
		item_in.d    = $signed(s_tdata[8*W +: W]);
		item_in.aph  = $signed(s_tdata[9*W +: W]);
		item_in.apv  = $signed(s_tdata[10*W +: W]);
		// Negated half length for the second-order drift terms.
		item_in.nh   = -(item_in.len >>> 1);
		item_in.bad  = (item_in.op == OP_BAD) || (item_in.len < 0)
			|| (item_in.aph <= 0) || (item_in.apv <= 0)
			|| ((item_in.op != OP_DRIFT) && ((item_in.k0 == 0) || (p0_q == '0)));
		dp           = $signed({1'b0, s_tdata[2*W +: W]}) - $signed({1'b0, p0_q});
		// When K0 and P-P0 have opposite signs the correction raises K.
		item_in.kadd = (item_in.k0 < 0) != dp[W];
		mk_in        = mag32(item_in.k0);
		mdp_in       = dp[W] ? W'(-dp) : dp[W-1:0];
	end

	item_t item_s [1:NST];
	logic [W-1:0] mk_s1;
	logic [W-1:0] mdp_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			item_s[1] <= item_in;
			mk_s1     <= mk_in;
			mdp_s1    <= mdp_in;
		end
		for (int i = 2; i <= NST; i++)
			if (en[i])
				item_s[i] <= item_s[i-1];
	end

	// Stage 2: magnitude of K0*(P-P0).
	logic [2*W-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (en[2])
			prod_s2 <= mk_s1 * mdp_s1;
	end

	// Stage 3: the quotient is needed to 34 bits only; anything larger clamps.
	logic [W-1:0]     rem_s3;
	logic [QBITS-1:0] nq_s3;
	logic             ovf_s3;

	always_ff @(posedge clk) begin
		if (en[ST_DIV0]) begin
			rem_s3 <= W'(prod_s2[2*W-2:QBITS]);
			nq_s3  <= prod_s2[QBITS-1:0];
			ovf_s3 <= W'(prod_s2[2*W-2:QBITS]) >= p0_q;
		end
	end

	logic [QBITS-1:0] quot_div;
	logic             ovf_div;

	bept_div u_div (
		.clk     (clk),
		.en      (en[ST_K-1:ST_DIV0+1]),
		.divisor (p0_q),
		.rem_in  (rem_s3),
		.nq_in   (nq_s3),
		.ovf_in  (ovf_s3),
		.quot    (quot_div),
		.ovf     (ovf_div)
	);

	// Stage 21: corrected strength K, saturated.
	logic [QBITS-1:0]   qc;
	logic signed [35:0] qs;
	logic signed [35:0] ksum;
	logic signed [W-1:0] k_s21;

	always_comb begin
		qc   = (ovf_div || (quot_div > Q_CLAMP)) ? Q_CLAMP : quot_div;
		qs   = $signed({2'b00, qc});
		ksum = item_s[ST_K-1].kadd ? 36'(item_s[ST_K-1].k0) + qs
			: 36'(item_s[ST_K-1].k0) - qs;
	end

	always_ff @(posedge clk) begin
		if (en[ST_K])
			k_s21 <= sat32(41'(ksum));
	end

	// Stage 22: integrated strength KL.
	logic signed [W-1:0] kl_s22;

	always_ff @(posedge clk) begin
		if (en[ST_KL])
			kl_s22 <= qmul(33'(k_s21), item_s[ST_KL-1].len);
	end

	// Stage 23: first-level products. The f terms carry the first order of
	// drift and quadrupole, the g terms the first factor of second order.
	item_t               it1;
	logic                drift1;
	logic signed [W-1:0] hk;
	logic signed [W:0]   nkl;
	logic signed [W:0]   nhk;
	logic signed [W-1:0] f0_s23, f1_s23, g0_s23, g1_s23, g2_s23;

	always_comb begin
		it1    = item_s[ST_M1-1];
		drift1 = (it1.op == OP_DRIFT);
		hk     = kl_s22 >>> 1;
		nkl    = -(33'(kl_s22));
		nhk    = -(33'(hk));
	end

	always_ff @(posedge clk) begin
		if (en[ST_M1]) begin
			f0_s23 <= drift1 ? qmul(33'(it1.len), it1.xa) : qmul(nkl, it1.x);
			f1_s23 <= drift1 ? qmul(33'(it1.len), it1.ya) : qmul(33'(kl_s22), it1.y);
			g0_s23 <= drift1 ? qmul(33'(it1.nh), it1.d)  : qmul(nhk, it1.x);
			g1_s23 <= drift1 ? qmul(33'(it1.nh), it1.xa) : qmul(33'(hk), it1.x);
			g2_s23 <= drift1 ? qmul(33'(it1.nh), it1.ya) : qmul(33'(hk), it1.y);
		end
	end

	// Stage 24: second-level products. For the sextupole, terms 0 and 5 feed
	// the horizontal angle and terms 1 and 3 the vertical angle.
	item_t               it2;
	logic                drift2;
	logic signed [W-1:0] f0_s24, f1_s24;
	logic signed [W-1:0] term_s24 [6];

	always_comb begin
		it2    = item_s[ST_M2-1];
		drift2 = (it2.op == OP_DRIFT);
	end

	always_ff @(posedge clk) begin
		if (en[ST_M2]) begin
			f0_s24      <= f0_s23;
			f1_s24      <= f1_s23;
			term_s24[0] <= qmul(33'(g0_s23), drift2 ? it2.xa : it2.x);
			term_s24[1] <= qmul(33'(g1_s23), drift2 ? it2.d  : it2.y);
			term_s24[2] <= qmul(33'(g0_s23), it2.ya);
			term_s24[3] <= qmul(33'(g2_s23), drift2 ? it2.d  : it2.x);
			term_s24[4] <= qmul(33'(g1_s23), it2.xa);
			term_s24[5] <= qmul(33'(g2_s23), drift2 ? it2.ya : it2.y);
		end
	end

	// Stage 25: exact sums, saturated once.
	item_t              it3;
	coord_t             res_in;
	logic signed [33:0] t01, t23, t45, t05, t13;

	always_comb begin
		it3 = item_s[ST_SUM-1];
		t01 = second ? 34'(term_s24[0]) + 34'(term_s24[1]) : '0;
		t23 = second ? 34'(term_s24[2]) + 34'(term_s24[3]) : '0;
		t45 = second ? 34'(term_s24[4]) + 34'(term_s24[5]) : '0;
		t05 = second ? 34'(term_s24[0]) + 34'(term_s24[5]) : '0;
		t13 = second ? 34'(term_s24[1]) + 34'(term_s24[3]) : '0;
		res_in.x  = it3.x;
		res_in.xa = it3.xa;
		res_in.y  = it3.y;
		res_in.ya = it3.ya;
		res_in.l  = it3.l;
		if (!it3.bad) begin
			case (it3.op)
				OP_DRIFT: begin
					res_in.x = sat32(41'(34'(it3.x) + 34'(f0_s24) + t01));
					res_in.y = sat32(41'(34'(it3.y) + 34'(f1_s24) + t23));
					res_in.l = sat32(41'(34'(it3.l) + t45));
				end
				OP_QUAD: begin
					res_in.xa = sat32(41'(34'(it3.xa) + 34'(f0_s24)));
					res_in.ya = sat32(41'(34'(it3.ya) + 34'(f1_s24)));
				end
				OP_SEXT: begin
					res_in.xa = sat32(41'(34'(it3.xa) + t05));
					res_in.ya = sat32(41'(34'(it3.ya) + t13));
				end
				default: res_in.x = it3.x;
			endcase
		end
	end

	coord_t res_s [ST_SUM:NST];

	always_ff @(posedge clk) begin
		if (en[ST_SUM])
			res_s[ST_SUM] <= res_in;
		for (int i = ST_SUM + 1; i <= NST; i++)
			if (en[i])
				res_s[i] <= res_s[i-1];
	end

	// Stages 26 to 29: aperture at entrance and at exit, in parallel.
	logic ent_inside;
	logic ext_inside;

	bept_ellipse u_ent (
		.clk        (clk),
		.en         (en[NST:ST_SUM+1]),
		.px         (item_s[ST_SUM].x),
		.py         (item_s[ST_SUM].y),
		.aph        (item_s[ST_SUM].aph),
		.apv        (item_s[ST_SUM].apv),
		.in_ellipse (ent_inside)
	);

	bept_ellipse u_ext (
		.clk        (clk),
		.en         (en[NST:ST_SUM+1]),
		.px         (res_s[ST_SUM].x),
		.py         (res_s[ST_SUM].y),
		.aph        (item_s[ST_SUM].aph),
		.apv        (item_s[ST_SUM].apv),
		.in_ellipse (ext_inside)
	);

	// Output stage.
	assign m_tdata = {item_s[NST].d, res_s[NST].l, res_s[NST].ya, res_s[NST].y,
		res_s[NST].xa, res_s[NST].x};
	assign m_tuser = {item_s[NST].bad, ent_inside & ext_inside & ~item_s[NST].bad};

	// A rejected element never reports a surviving particle.
	`BEPT_ASSERT_IMP(a_bad_not_survived, m_tvalid, !(m_tuser[1] && m_tuser[0]),
		"rejected element reported as survived")
	// Input backpressure only when every stage is full and the output stalls.
	`BEPT_ASSERT_IMP(a_ready_only_full, !s_tready, (&vld_s) && !m_tready,
		"input stalled with an empty stage")
	// A rejected element leaves the coordinates untouched.
	`BEPT_ASSERT_IMP(a_bad_passthrough, m_tvalid && m_tuser[1],
		(res_s[NST].x == item_s[NST].x) && (res_s[NST].xa == item_s[NST].xa)
		&& (res_s[NST].y == item_s[NST].y) && (res_s[NST].ya == item_s[NST].ya)
		&& (res_s[NST].l == item_s[NST].l),
		"rejected element changed the coordinates")
	// The invalid element kind is always rejected.
	`BEPT_ASSERT_IMP(a_invalid_op_bad, vld_s[1] && (item_s[1].op == OP_BAD),
		item_s[1].bad, "invalid element kind not rejected")

endmodule

// ----- tb/beam_element_particle_tracker_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Particle tracker result checker
// Watches the input, result and register-write channels of the tracker,
// predicts every result from its own copy of the registers and compares each
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module beam_element_particle_tracker_unit_checker import bept_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [351:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [191:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data,
	output int           errors,
	output int           pending
);

	typedef struct {
		logic [191:0] coords;
		logic         survived;
		logic         bad_element;
	} track_result_t;

	track_result_t expected_tracks[$];
	logic [1:0]    order_reg;
	logic [31:0]   p0_reg;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Q8.24 product, floored, saturated.
	function automatic longint fx_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		return clamp32(p >>> 24);
	endfunction

	function automatic longint fx_term(input longint c, input longint a, input longint b);
		return fx_mul(fx_mul(c, a), b);
	endfunction

	function automatic logic [63:0] magnitude(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// Exact test of (x/aph)^2 + (y/apv)^2 <= 1.
	function automatic bit in_ellipse(input longint x, input longint y,
		input longint aph, input longint apv);
		logic [127:0] x2, y2, a2, b2;
		x2 = 128'(magnitude(x)) * 128'(magnitude(x));
		y2 = 128'(magnitude(y)) * 128'(magnitude(y));
		a2 = 128'(magnitude(aph)) * 128'(magnitude(aph));
		b2 = 128'(magnitude(apv)) * 128'(magnitude(apv));
		return (x2 * b2 + y2 * a2) <= (a2 * b2);
	endfunction

	function automatic track_result_t track_particle(input logic [1:0] op,
		input logic [351:0] d);
		track_result_t r;
		longint len, k0, p, aph, apv, dp, k, kl, nh, hk;
		longint c[6], acc[6];
		logic [63:0] q;
		bit second, bad;
		len = longint'($signed(d[31:0]));
		k0  = longint'($signed(d[63:32]));
		p   = longint'(d[95:64]);
		for (int i = 0; i < 6; i++) begin
			c[i] = longint'($signed(d[96 + 32*i +: 32]));
			acc[i] = c[i];
		end
		aph = longint'($signed(d[319:288]));
		apv = longint'($signed(d[351:320]));
		second = (order_reg == ORDER_SECOND);
		bad = (op == OP_BAD) || (len < 0) || (aph <= 0) || (apv <= 0) ||
			(op != OP_DRIFT && (k0 == 0 || p0_reg == 0));
		r.survived = 1'b0;
		if (!bad) begin
			if (op == OP_DRIFT) begin
				acc[0] += fx_mul(len, c[1]);
				acc[2] += fx_mul(len, c[3]);
				if (second) begin
					nh = -fx_mul(len, 64'sd8388608);
					acc[0] += fx_term(nh, c[5], c[1]) + fx_term(nh, c[1], c[5]);
					acc[2] += fx_term(nh, c[5], c[3]) + fx_term(nh, c[3], c[5]);
					acc[4] += fx_term(nh, c[1], c[1]) + fx_term(nh, c[3], c[3]);
				end
			end else begin
				// Momentum-corrected strength, correction truncated toward zero.
				dp = p - longint'(p0_reg);
				q = (magnitude(k0) * magnitude(dp)) / 64'(p0_reg);
				if (q > 64'h2_0000_0000)
					q = 64'h2_0000_0000;
				if (((k0 < 0) != (dp < 0)) && dp != 0)
					k = k0 + longint'(q);
				else
					k = k0 - longint'(q);
				k = clamp32(k);
				kl = fx_mul(k, len);
				if (op == OP_QUAD) begin
					acc[1] += fx_mul(-kl, c[0]);
					acc[3] += fx_mul(kl, c[2]);
				end else if (second) begin
					hk = fx_mul(kl, 64'sd8388608);
					acc[1] += fx_term(-hk, c[0], c[0]) + fx_term(hk, c[2], c[2]);
					acc[3] += fx_term(hk, c[2], c[0]) + fx_term(hk, c[0], c[2]);
				end
			end
			for (int i = 0; i < 6; i++)
				acc[i] = clamp32(acc[i]);
			r.survived = in_ellipse(c[0], c[2], aph, apv) &&
				in_ellipse(acc[0], acc[2], aph, apv);
		end
		for (int i = 0; i < 6; i++)
			r.coords[32*i +: 32] = acc[i][31:0];
		r.bad_element = bad;
		return r;
	endfunction

	assign pending = expected_tracks.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_reg <= ORDER_RESET;
			p0_reg <= P0_RESET;
			errors <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ORDER)
					order_reg <= cfg_data[1:0];
				else
					p0_reg <= cfg_data;
			end
			if (s_tvalid && s_tready)
				expected_tracks.push_back(track_particle(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				track_result_t e;
				int fails;
				fails = 0;
				if (expected_tracks.size() == 0) begin
					$display("%0t: result with no item pending: %h %b", $time,
						m_tdata, m_tuser);
					fails = 1;
				end else begin
					e = expected_tracks.pop_front();
					for (int i = 0; i < 6; i++)
						if (m_tdata[32*i +: 32] !== e.coords[32*i +: 32]) begin
							$display("%0t: coordinate %0d expected %h got %h", $time, i,
								e.coords[32*i +: 32], m_tdata[32*i +: 32]);
							fails++;
						end
					if (m_tuser[0] !== e.survived) begin
						$display("%0t: survived expected %b got %b", $time,
							e.survived, m_tuser[0]);
						fails++;
					end
					if (m_tuser[1] !== e.bad_element) begin
						$display("%0t: bad_element expected %b got %b", $time,
							e.bad_element, m_tuser[1]);
						fails++;
					end
				end
				// All mismatches of one result are counted in a single update.
				errors <= errors + fails;
			end
		end
	end

endmodule

// ----- tb/beam_element_particle_tracker_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Particle tracker testbench
// Drives drift, quadrupole and sextupole items through the tracker under
// several register settings, with bursty input and a stalling receiver; a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module beam_element_particle_tracker_unit_tb import bept_pkg::*;;

	// Cycles allowed without any handshake before the run is declared hung.
	localparam int HANG_LIMIT = 4000;
	// Cycles to let the pipeline settle before a register write and at the end.
	localparam int SETTLE = 40;
	localparam int RANDOM_PER_PHASE = 117;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// elem_length, strength, momentum, x_pos, x_angle, y_pos, y_angle,
	// path_delta, momentum_dev, aperture_h, aperture_v (32 bits each)
	logic [351:0] s_tdata;
	// opcode
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	// x_out, xa_out, y_out, ya_out, path_out, dev_out (32 bits each)
	logic [191:0] m_tdata;
	// survived, bad_element
	logic [1:0]   m_tuser;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_data;
	int           errors;
	int           pending;

	// One element and particle as the sender sees it.
	typedef struct {
		logic [1:0]  op;
		logic [31:0] len, k0, p, x, xa, y, ya, l, d, aph, apv;
	} particle_item_t;

	int burst_left;
	int hold_requests;
	int idle_cycles;

	beam_element_particle_tracker_unit u_top (.*);

	beam_element_particle_tracker_unit_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The watchdog counts cycles in which nothing moves on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == HANG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// The receiver switches its stall pattern at random among always ready,
	// ready half the time and ready only a quarter of the time. A hold request
	// from the stimulus makes it refuse results for a long stretch so the
	// pipeline fills and pushes back on the sender.
	initial begin
		int mode, held, served;
		m_tready = 1'b0;
		mode = 0;
		served = 0;
		forever begin
			@(negedge clk);
			if (served != hold_requests) begin
				served = hold_requests;
				held = 300;
			end
			if (held > 0) begin
				held--;
				m_tready <= 1'b0;
			end else begin
				if ($urandom_range(63) == 0)
					mode = $urandom_range(2);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(1);
					default: m_tready <= ($urandom_range(3) == 0);
				endcase
			end
		end
	end

	// Offers one item and returns once it has been taken. Items come in bursts
	// of random length with random gaps between bursts; some bursts have no
	// gap at all so back-to-back stretches also occur.
	task automatic offer_item(input particle_item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(30, 1);
			if ($urandom_range(2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(20, 1)) @(negedge clk);
			end
		end
		s_tuser <= it.op;
		s_tdata <= {it.apv, it.aph, it.d, it.l, it.ya, it.y, it.xa, it.x, it.p, it.k0, it.len};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		burst_left--;
	endtask

	// Register writes happen only with the pipeline empty.
	task automatic write_register(input logic idx, input logic [31:0] value);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// A coordinate that is usually within 2.0 (Q8.24) of the axis and
	// sometimes anywhere in the full range, so saturation is reached too.
	function automatic logic [31:0] pick_coord();
		if ($urandom_range(4) == 0)
			return $urandom();
		return 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
	endfunction

	function automatic particle_item_t random_particle(input logic [31:0] p0);
		particle_item_t it;
		int r;
		r = $urandom_range(99);
		it.op = (r < 4) ? OP_BAD : 2'($urandom_range(2));
		it.len = ($urandom_range(5) == 0) ? ($urandom() & 32'h7FFF_FFFF)
			: $urandom_range(32'h0400_0000);
		it.k0 = ($urandom_range(5) == 0) ? $urandom()
			: 32'($signed($urandom_range(32'h0800_0000, 1)) - 32'sh0400_0000);
		if (it.k0 == 0)
			it.k0 = 32'h0100_0000;
		it.p = ($urandom_range(3) == 0) ? $urandom()
			: p0 + 32'($urandom_range(2000)) - 32'd1000;
		it.x = pick_coord();
		it.xa = pick_coord();
		it.y = pick_coord();
		it.ya = pick_coord();
		it.l = pick_coord();
		it.d = ($urandom_range(3) == 0) ? $urandom()
			: 32'($signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
		it.aph = ($urandom_range(7) == 0) ? ($urandom() & 32'h7FFF_FFFF)
			: $urandom_range(32'h0800_0000, 32'h0040_0000);
		it.apv = ($urandom_range(7) == 0) ? ($urandom() & 32'h7FFF_FFFF)
			: $urandom_range(32'h0800_0000, 32'h0040_0000);
		// A small share of noise: rejected lengths, strengths and apertures.
		if (r >= 4 && r < 10) begin
			case ($urandom_range(3))
				0: it.len = $urandom() | 32'h8000_0000;
				1: it.k0 = 32'h0;
				2: it.aph = ($urandom_range(1) != 0) ? 32'h0 : ($urandom() | 32'h8000_0000);
				default: it.apv = ($urandom_range(1) != 0) ? 32'h0 : ($urandom() | 32'h8000_0000);
			endcase
		end
		return it;
	endfunction

	task automatic run_random(input logic [31:0] p0);
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			offer_item(random_particle(p0));
	endtask

	// Directed items: each element kind, the extremes of the fields and the
	// rejection rules on kind, length, strength and aperture, second order on.
	task automatic run_directed();
		particle_item_t base, it;
		base.op = OP_DRIFT;
		base.len = 32'h0100_0000;
		base.k0 = 32'h0100_0000;
		base.p = 32'h0001_0000;
		base.x = 32'h0080_0000;
		base.xa = 32'h0010_0000;
		base.y = 32'hFF80_0000;
		base.ya = 32'hFFF0_0000;
		base.l = 32'h0;
		base.d = 32'h0008_0000;
		base.aph = 32'h0200_0000;
		base.apv = 32'h0200_0000;
		for (int n = 0; n < 22; n++) begin
			it = base;
			case (n)
				0: ;
				1: it.op = OP_QUAD;
				2: it.op = OP_SEXT;
				3: it.op = OP_BAD;
				4: it.len = 32'h8000_0000;
				5: begin it.op = OP_QUAD; it.k0 = 32'h0; end
				6: begin it.op = OP_SEXT; it.k0 = 32'h0; end
				7: it.aph = 32'h0;
				8: it.apv = 32'h8000_0000;
				9: it.len = 32'h0;
				10: begin
					// Largest fields everywhere: every sum saturates.
					it.len = 32'h7FFF_FFFF;
					it.x = 32'h7FFF_FFFF; it.xa = 32'h7FFF_FFFF;
					it.y = 32'h8000_0000; it.ya = 32'h8000_0000;
					it.l = 32'h7FFF_FFFF; it.d = 32'h8000_0000;
					it.aph = 32'h7FFF_FFFF; it.apv = 32'h7FFF_FFFF;
				end
				11: begin
					// Huge momentum correction, clamped before saturation.
					it.op = OP_QUAD; it.k0 = 32'h7FFF_FFFF; it.p = 32'hFFFF_FFFF;
					it.len = 32'h7FFF_FFFF;
				end
				12: begin it.op = OP_SEXT; it.k0 = 32'h8000_0000; it.p = 32'h0; end
				13: begin it.op = OP_QUAD; it.k0 = 32'h8000_0000; it.p = 32'hFFFF_FFFF; end
				14: begin it.op = OP_SEXT; it.x = 32'h7FFF_FFFF; it.y = 32'h8000_0000; end
				15: begin it.x = 32'h0200_0000; it.y = 32'h0; end
				16: begin it.x = 32'h0200_0001; it.y = 32'h0; end
				17: begin it.op = OP_QUAD; it.k0 = 32'hFF00_0000; it.p = 32'h0000_8000; end
				18: begin it.aph = 32'h0000_0001; it.apv = 32'h0000_0001; it.x = 32'h0; it.y = 32'h0;
					it.xa = 32'h0; it.ya = 32'h0; end
				19: begin it.aph = 32'hFFFF_FFFF; it.op = OP_QUAD; end
				20: begin it.op = OP_SEXT; it.len = 32'h7FFF_FFFF; it.k0 = 32'h7FFF_FFFF;
					it.x = 32'h8000_0000; it.y = 32'h7FFF_FFFF; end
				default: begin it.x = 32'hFFFF_FFFF; it.xa = 32'hFFFF_FFFF; it.d = 32'h7FFF_FFFF; end
			endcase
			offer_item(it);
		end
	endtask

	initial begin
		logic [31:0] p0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ORDER;
		cfg_data = '0;
		burst_left = 0;
		hold_requests = 0;
		idle_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: first order, unit reference momentum.
		run_random(P0_RESET);

		write_register(REG_ORDER, 32'(ORDER_SECOND));
		run_directed();
		run_random(P0_RESET);

		// Smallest reference momentum; the receiver holds off early on while
		// the sender keeps offering items.
		write_register(REG_P0, 32'd1);
		hold_requests++;
		run_random(32'd1);

		// Unused order codes fall back to first order.
		write_register(REG_ORDER, 32'd0);
		write_register(REG_P0, 32'hFFFF_FFFF);
		run_random(32'hFFFF_FFFF);

		write_register(REG_ORDER, 32'hFFFF_FFFF);
		p0 = $urandom() | 32'h1;
		write_register(REG_P0, p0);
		run_random(p0);

		write_register(REG_ORDER, 32'(ORDER_SECOND));
		p0 = $urandom_range(32'h0010_0000, 32'h0000_4000);
		write_register(REG_P0, p0);
		run_random(p0);

		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
